### src/raft_consensus_node_engine_top_macros.svh
// Assertion macros for the Raft node engine.
// Used by the top level only. It needs clk and rst_n in scope.
`ifndef RAFT_CONSENSUS_NODE_ENGINE_TOP_MACROS_SVH
`define RAFT_CONSENSUS_NODE_ENGINE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the trigger.
`define RCNE_ASSERT_SAME(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the trigger.
`define RCNE_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

### src/rcne_pkg.sv
// Shared types, codes and constants of the Raft node engine.
// No dependencies; imported by the controller, datapath, top level and testbench.
`timescale 1ns / 1ps

package rcne_pkg;

  // Log storage geometry.
  localparam int LOG_DEPTH = 1024;
  localparam int LOG_AW    = $clog2(LOG_DEPTH);
  localparam int CMD_W     = 64;
  localparam int IDX_W     = 31;
  localparam int MEM_W     = IDX_W + CMD_W;

  localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};
  localparam logic [4:0]       NO_VOTE = 5'd16;

  typedef enum logic [2:0] {
    CMD_APP_HDR  = 3'd0,
    CMD_APP_ENT  = 3'd1,
    CMD_VOTE_REQ = 3'd2,
    CMD_VOTE_RSP = 3'd3,
    CMD_TIMEOUT  = 3'd4,
    CMD_APPLY    = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_APP_RSP  = 3'd0,
    KIND_VOTE_RSP = 3'd1,
    KIND_VOTE_REQ = 3'd2,
    KIND_APPLY    = 3'd3,
    KIND_LEADER   = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_STALE    = 3'd1,
    ST_TOO_NEW  = 3'd2,
    ST_TOO_OLD  = 3'd3,
    ST_MISMATCH = 3'd4,
    ST_FULL     = 3'd5,
    ST_VOTED    = 3'd6,
    ST_BEHIND   = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    ROLE_FOLLOWER  = 2'd0,
    ROLE_CANDIDATE = 2'd1,
    ROLE_LEADER    = 2'd2
  } role_t;

  typedef enum logic [2:0] {
    REG_NODE_ID    = 3'd0,
    REG_NODE_COUNT = 3'd1,
    REG_SNAP_INDEX = 3'd2,
    REG_SNAP_TERM  = 3'd3,
    REG_REST_TERM  = 3'd4,
    REG_REST_VOTE  = 3'd5
  } reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic rd_item;
    logic eval;
    logic srch_rd;
    logic srch_cmp;
    logic push;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_search;
    logic has_res;
    logic srch_end;
    logic srch_hit;
    logic out_free;
  } sts_t;

  // Saturating increment of an index or term.
  function automatic logic [IDX_W-1:0] inc_sat(input logic [IDX_W-1:0] v);
    inc_sat = (v == IDX_MAX) ? IDX_MAX : v + 1'b1;
  endfunction

endpackage

### src/rcne_ram.sv
// Generic simple dual-port RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module rcne_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/rcne_ctrl.sv
// Controller state machine of the Raft node engine.
// Depends on rcne_pkg; drives the datapath through ctl_t, reads sts_t.
`timescale 1ns / 1ps

module rcne_ctrl import rcne_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output ctl_t ctl
);

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_READ;
      end
      S_READ: state_nxt = S_EVAL;
      S_EVAL: begin
        if (sts.need_search) state_nxt = S_SRCH_RD;
        else if (sts.has_res) state_nxt = S_EMIT;
        else state_nxt = S_IDLE;
      end
      S_SRCH_RD: begin
        state_nxt = sts.srch_end ? S_EMIT : S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        state_nxt = sts.srch_hit ? S_EMIT : S_SRCH_RD;
      end
      S_EMIT: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        ctl.load = in_valid;
      end
      S_READ:     ctl.rd_item  = 1'b1;
      S_EVAL:     ctl.eval     = 1'b1;
      S_SRCH_RD:  ctl.srch_rd  = 1'b1;
      S_SRCH_CMP: ctl.srch_cmp = 1'b1;
      S_EMIT:     ctl.push     = sts.out_free;
      default:    ctl          = '0;
    endcase
  end

endmodule

### src/rcne_dpath.sv
// Datapath of the Raft node engine: node state, item latch, hint search,
// result and output registers. Depends on rcne_pkg and rcne_ram.
`timescale 1ns / 1ps

module rcne_dpath import rcne_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  ctl_t              ctl,
  output sts_t              sts,
  input  logic              cfg_valid,
  input  logic [2:0]        cfg_index,
  input  logic [IDX_W-1:0]  cfg_data,
  input  logic [2:0]        in_cmd,
  input  logic [IDX_W-1:0]  in_msg_term,
  input  logic [IDX_W-1:0]  in_ref_index,
  input  logic [IDX_W-1:0]  in_ref_term,
  input  logic [IDX_W-1:0]  in_leader_commit,
  input  logic [CMD_W-1:0]  in_entry_command,
  input  logic [3:0]        in_sender_id,
  input  logic              in_vote_granted,
  input  logic              in_last_entry,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_kind,
  output logic [IDX_W-1:0]  out_term,
  output logic [2:0]        out_status,
  output logic              out_success,
  output logic [IDX_W-1:0]  out_index,
  output logic [IDX_W-1:0]  out_last_term,
  output logic [CMD_W-1:0]  out_command,
  output logic              out_timer_reset,
  output logic              out_more_pending,
  output logic [1:0]        out_role
);

  // Configuration and node state.
  logic [3:0]       node_id_r;
  logic [4:0]       node_cnt_r;
  logic [IDX_W-1:0] snap_idx_r, snap_term_r;
  logic [IDX_W-1:0] term_r, commit_r, applied_r, end_r, pend_r;
  logic [4:0]       vote_r, tally_r;
  role_t            role_r;
  logic             open_r;

  logic [IDX_W-1:0] term_nxt, commit_nxt, applied_nxt, end_nxt, pend_nxt;
  logic [4:0]       vote_nxt, tally_nxt;
  role_t            role_nxt;
  logic             open_nxt;

  // Latched item.
  cmd_t             it_cmd_r;
  logic [IDX_W-1:0] it_mt_r, it_ri_r, it_rt_r, it_lc_r;
  logic [CMD_W-1:0] it_cw_r;
  logic [3:0]       it_sid_r;
  logic             it_vg_r, it_le_r;

  // Pending result.
  kind_t            res_kind_r, res_kind_nxt;
  status_t          res_status_r, res_status_nxt;
  logic             res_ok_r, res_ok_nxt, res_timer_r, res_timer_nxt;
  logic [IDX_W-1:0] res_index_r, res_index_nxt, res_last_r, res_last_nxt;
  logic [CMD_W-1:0] res_cmd_r, res_cmd_nxt;
  logic [IDX_W-1:0] res_term_r;
  logic             res_more_r;
  role_t            res_role_r;
  logic             has_res, need_search;

  // Hint search.
  logic [IDX_W-1:0] srch_idx_r, base_r;

  // Output register.
  logic             out_valid_r;

  // Log memory.
  logic             mem_we;
  logic [LOG_AW-1:0] mem_waddr, mem_raddr;
  logic [MEM_W-1:0] mem_wdata, mem_rdata;
  logic [IDX_W-1:0] rd_term;
  logic [CMD_W-1:0] rd_cmd;

  logic [IDX_W-1:0] rd_ix, tat, held, item_off, srch_off;
  logic [IDX_W:0]   end_p1;
  logic [4:0]       majority, tally_inc, vote_eff;

  assign rd_term  = mem_rdata[MEM_W-1:CMD_W];
  assign rd_cmd   = mem_rdata[CMD_W-1:0];
  assign majority = {1'b0, node_cnt_r[4:1]} + 5'd1;
  assign end_p1   = {1'b0, end_r} + 1'b1;
  assign held     = end_r - snap_idx_r;

  // Index whose entry an item needs from the log.
  always_comb begin
    case (it_cmd_r)
      CMD_VOTE_REQ, CMD_TIMEOUT: rd_ix = end_r;
      CMD_APPLY:                 rd_ix = applied_r + 1'b1;
      default:                   rd_ix = it_ri_r;
    endcase
  end

  assign item_off  = rd_ix - snap_idx_r - 1'b1;
  assign srch_off  = srch_idx_r - snap_idx_r - 1'b1;
  assign mem_raddr = ctl.srch_rd ? srch_off[LOG_AW-1:0] : item_off[LOG_AW-1:0];
  assign tat       = (rd_ix <= snap_idx_r) ? snap_term_r : rd_term;
  assign mem_waddr = item_off[LOG_AW-1:0];
  assign mem_wdata = {it_rt_r, it_cw_r};

  rcne_ram #(
    .WIDTH (MEM_W),
    .DEPTH (LOG_DEPTH)
  ) u_log (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Evaluation of one item against the node state.
  always_comb begin
    term_nxt = term_r;  commit_nxt = commit_r;  applied_nxt = applied_r;
    end_nxt  = end_r;   pend_nxt   = pend_r;    vote_nxt    = vote_r;
    tally_nxt = tally_r; role_nxt  = role_r;    open_nxt    = open_r;
    res_kind_nxt = KIND_APP_RSP; res_status_nxt = ST_OK; res_ok_nxt = 1'b0;
    res_index_nxt = '0; res_last_nxt = '0; res_cmd_nxt = '0; res_timer_nxt = 1'b0;
    has_res = 1'b0; need_search = 1'b0; mem_we = 1'b0;
    tally_inc = (tally_r < 5'd31) ? tally_r + 5'd1 : 5'd31;
    vote_eff  = (it_mt_r > term_r) ? NO_VOTE : vote_r;
    case (it_cmd_r)
      CMD_APP_HDR: begin
        has_res = 1'b1;
        open_nxt = 1'b0;
        if (it_mt_r < term_r) begin
          res_status_nxt = ST_STALE;
        end else begin
          if (it_mt_r > term_r) begin
            term_nxt = it_mt_r;
            vote_nxt = NO_VOTE;
          end
          role_nxt = ROLE_FOLLOWER;
          tally_nxt = '0;
          res_timer_nxt = 1'b1;
          if (it_ri_r > end_r) begin
            res_status_nxt = ST_TOO_NEW;
            res_index_nxt  = inc_sat(end_r);
          end else if (it_ri_r < snap_idx_r) begin
            res_status_nxt = ST_TOO_OLD;
            res_index_nxt  = inc_sat(snap_idx_r);
          end else if (tat != it_rt_r) begin
            res_status_nxt = ST_MISMATCH;
            res_index_nxt  = it_ri_r;
            need_search    = 1'b1;
          end else begin
            pend_nxt = it_lc_r;
            if (it_le_r) begin
              if (it_lc_r > commit_r) begin
                commit_nxt = (it_lc_r < end_r) ? it_lc_r : end_r;
              end
              res_ok_nxt    = 1'b1;
              res_index_nxt = end_r;
            end else begin
              open_nxt = 1'b1;
              has_res  = 1'b0;
            end
          end
        end
      end
      CMD_APP_ENT: begin
        if (open_r) begin
          res_timer_nxt = 1'b1;
          if (it_ri_r <= snap_idx_r || it_ri_r <= commit_r) begin
            end_nxt = end_r;
          end else if (it_ri_r <= end_r) begin
            if (rd_term != it_rt_r) begin
              mem_we  = 1'b1;
              end_nxt = it_ri_r;
            end
          end else if ({1'b0, it_ri_r} == end_p1) begin
            if (held >= IDX_W'(LOG_DEPTH)) begin
              has_res = 1'b1;
              res_status_nxt = ST_FULL;
              res_index_nxt  = end_r;
            end else begin
              mem_we  = 1'b1;
              end_nxt = it_ri_r;
            end
          end else begin
            has_res = 1'b1;
            res_status_nxt = ST_TOO_NEW;
            res_index_nxt  = inc_sat(end_r);
          end
          if (has_res) begin
            open_nxt = 1'b0;
          end else if (it_le_r) begin
            // Final entry: close the append and advance the commit index.
            has_res  = 1'b1;
            open_nxt = 1'b0;
            if (pend_r > commit_r) begin
              commit_nxt = (pend_r < end_nxt) ? pend_r : end_nxt;
            end
            res_ok_nxt    = 1'b1;
            res_index_nxt = end_nxt;
          end
        end
      end
      CMD_VOTE_REQ: begin
        has_res = 1'b1;
        res_kind_nxt = KIND_VOTE_RSP;
        if (it_mt_r < term_r) begin
          res_status_nxt = ST_STALE;
        end else begin
          if (it_mt_r > term_r) begin
            term_nxt = it_mt_r;  vote_nxt = NO_VOTE;  role_nxt = ROLE_FOLLOWER;
            tally_nxt = '0;      open_nxt = 1'b0;
          end
          if (!(it_rt_r > tat || (it_rt_r == tat && it_ri_r >= end_r))) begin
            res_status_nxt = ST_BEHIND;
          end else if (vote_eff != NO_VOTE && vote_eff != {1'b0, it_sid_r}) begin
            res_status_nxt = ST_VOTED;
          end else begin
            vote_nxt = {1'b0, it_sid_r};
            res_ok_nxt = 1'b1;
            res_timer_nxt = 1'b1;
          end
        end
      end
      CMD_VOTE_RSP: begin
        if (it_mt_r > term_r) begin
          term_nxt = it_mt_r;  vote_nxt = NO_VOTE;  role_nxt = ROLE_FOLLOWER;
          tally_nxt = '0;      open_nxt = 1'b0;
        end else if (it_mt_r == term_r && role_r == ROLE_CANDIDATE && it_vg_r) begin
          if (tally_inc >= majority) begin
            role_nxt = ROLE_LEADER;
            tally_nxt = '0;
            has_res = 1'b1;
            res_kind_nxt = KIND_LEADER;
            res_ok_nxt = 1'b1;
            res_index_nxt = end_r;
          end else begin
            tally_nxt = tally_inc;
          end
        end
      end
      CMD_TIMEOUT: begin
        if (role_r != ROLE_LEADER) begin
          has_res = 1'b1;
          term_nxt = inc_sat(term_r);
          vote_nxt = {1'b0, node_id_r};
          open_nxt = 1'b0;
          res_timer_nxt = 1'b1;
          res_index_nxt = end_r;
          if (majority <= 5'd1) begin
            // Single node cluster wins at once with its own vote.
            role_nxt = ROLE_LEADER;
            tally_nxt = '0;
            res_kind_nxt = KIND_LEADER;
            res_ok_nxt = 1'b1;
          end else begin
            role_nxt = ROLE_CANDIDATE;
            tally_nxt = 5'd1;
            res_kind_nxt = KIND_VOTE_REQ;
            res_last_nxt = tat;
          end
        end
      end
      CMD_APPLY: begin
        if (applied_r < commit_r) begin
          has_res = 1'b1;
          applied_nxt = rd_ix;
          res_kind_nxt = KIND_APPLY;
          res_index_nxt = rd_ix;
          res_cmd_nxt = (rd_ix > snap_idx_r) ? rd_cmd : '0;
        end
      end
      default: has_res = 1'b0;
    endcase
    if (!ctl.eval) mem_we = 1'b0;
  end

  // Node state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_id_r <= '0;  node_cnt_r <= 5'd3;  snap_idx_r <= '0;  snap_term_r <= '0;
      term_r <= '0;  vote_r <= NO_VOTE;  role_r <= ROLE_FOLLOWER;  commit_r <= '0;
      applied_r <= '0;  end_r <= '0;  tally_r <= '0;  open_r <= 1'b0;  pend_r <= '0;
    end else if (cfg_valid) begin
      case (reg_t'(cfg_index))
        REG_NODE_ID:    node_id_r  <= cfg_data[3:0];
        REG_NODE_COUNT: node_cnt_r <= cfg_data[4:0];
        REG_SNAP_INDEX: begin
          snap_idx_r <= cfg_data;  end_r <= cfg_data;  applied_r <= cfg_data;
          commit_r <= '0;  pend_r <= '0;  open_r <= 1'b0;
        end
        REG_SNAP_TERM:  snap_term_r <= cfg_data;
        REG_REST_TERM:  term_r <= cfg_data;
        REG_REST_VOTE:  vote_r <= (cfg_data[4:0] > NO_VOTE) ? NO_VOTE : cfg_data[4:0];
        default: ;
      endcase
    end else if (ctl.eval) begin
      term_r <= term_nxt;  vote_r <= vote_nxt;  role_r <= role_nxt;
      commit_r <= commit_nxt;  applied_r <= applied_nxt;  end_r <= end_nxt;
      tally_r <= tally_nxt;  open_r <= open_nxt;  pend_r <= pend_nxt;
    end
  end

  // Item latch.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      it_cmd_r <= cmd_t'(in_cmd);     it_mt_r <= in_msg_term;
      it_ri_r  <= in_ref_index;       it_rt_r <= in_ref_term;
      it_lc_r  <= in_leader_commit;   it_cw_r <= in_entry_command;
      it_sid_r <= in_sender_id;       it_vg_r <= in_vote_granted;
      it_le_r  <= in_last_entry;
    end
  end

  // Pending result and the mismatch hint walk.
  always_ff @(posedge clk) begin
    if (ctl.eval) begin
      res_kind_r <= res_kind_nxt;    res_status_r <= res_status_nxt;
      res_ok_r   <= res_ok_nxt;      res_index_r  <= res_index_nxt;
      res_last_r <= res_last_nxt;    res_cmd_r    <= res_cmd_nxt;
      res_timer_r <= res_timer_nxt;  res_term_r   <= term_nxt;
      res_more_r <= (applied_nxt < commit_nxt);
      res_role_r <= role_nxt;
      srch_idx_r <= it_ri_r;
      base_r     <= tat;
    end else if (ctl.srch_cmp) begin
      if (rd_term != base_r) begin
        res_index_r <= srch_idx_r + 1'b1;
      end else begin
        srch_idx_r <= srch_idx_r - 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      out_kind <= res_kind_r;        out_term <= res_term_r;
      out_status <= res_status_r;    out_success <= res_ok_r;
      out_index <= res_index_r;      out_last_term <= res_last_r;
      out_command <= res_cmd_r;      out_timer_reset <= res_timer_r;
      out_more_pending <= res_more_r;
      out_role <= res_role_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign sts.need_search = need_search;
  assign sts.has_res     = has_res;
  assign sts.srch_end    = (srch_idx_r <= snap_idx_r);
  assign sts.srch_hit    = (rd_term != base_r);
  assign sts.out_free    = !out_valid_r || out_ready;

endmodule

### src/raft_consensus_node_engine_top.sv
// Top level of the Raft node engine: controller, datapath and assertions.
// Depends on rcne_pkg, rcne_ctrl, rcne_dpath and the assertion macro header.
//
//   Channel  Direction  Handshake            Carries
//   in_      input      in_valid/in_ready    one message or event
//   out_     output     out_valid/out_ready  zero or one result per item
//   cfg_     input      cfg_valid/cfg_ready  register index and write data
//
// An item passes through a read and an evaluate state, and an emit state when it
// gives a result; the read state waits on the registered read of the log memory.
// A mismatched append header adds a hint walk, one log read and compare per entry.
// Reset is synchronous on rst_n and leaves the log contents undefined.
// The output register lets a new item enter while a result waits for out_ready.
`timescale 1ns / 1ps
`include "raft_consensus_node_engine_top_macros.svh"

module raft_consensus_node_engine_top import rcne_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [IDX_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_cmd,
  input  logic [IDX_W-1:0]  in_msg_term,
  input  logic [IDX_W-1:0]  in_ref_index,
  input  logic [IDX_W-1:0]  in_ref_term,
  input  logic [IDX_W-1:0]  in_leader_commit,
  input  logic [CMD_W-1:0]  in_entry_command,
  input  logic [3:0]        in_sender_id,
  input  logic              in_vote_granted,
  input  logic              in_last_entry,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_kind,
  output logic [IDX_W-1:0]  out_term,
  output logic [2:0]        out_status,
  output logic              out_success,
  output logic [IDX_W-1:0]  out_index,
  output logic [IDX_W-1:0]  out_last_term,
  output logic [CMD_W-1:0]  out_command,
  output logic              out_timer_reset,
  output logic              out_more_pending,
  output logic [1:0]        out_role
);

  ctl_t ctl;
  sts_t sts;

  // Register writes must arrive only while the engine is idle; the block does not enforce it.
  assign cfg_ready = 1'b1;

  rcne_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  rcne_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .sts              (sts),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_cmd           (in_cmd),
    .in_msg_term      (in_msg_term),
    .in_ref_index     (in_ref_index),
    .in_ref_term      (in_ref_term),
    .in_leader_commit (in_leader_commit),
    .in_entry_command (in_entry_command),
    .in_sender_id     (in_sender_id),
    .in_vote_granted  (in_vote_granted),
    .in_last_entry    (in_last_entry),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_term         (out_term),
    .out_status       (out_status),
    .out_success      (out_success),
    .out_index        (out_index),
    .out_last_term    (out_last_term),
    .out_command      (out_command),
    .out_timer_reset  (out_timer_reset),
    .out_more_pending (out_more_pending),
    .out_role         (out_role)
  );

  // Only one item is in flight, and its log read follows the transfer.
  `RCNE_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken while busy")
  `RCNE_ASSERT_NEXT(a_read_follows, in_valid && in_ready, ctl.rd_item, "no log read after transfer")
  // The controller issues at most one command per cycle.
  `RCNE_ASSERT_SAME(a_one_cmd, 1'b1, $onehot0(ctl), "overlapping datapath commands")
  // A pushed result always lands in a free output register.
  `RCNE_ASSERT_NEXT(a_push_shows, ctl.push, out_valid, "pushed result not presented")

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the Raft node engine top level.
// Depends on rcne_pkg and raft_consensus_node_engine_top; a built-in predictor checks every result.
`timescale 1ns / 1ps

module tb;
  import rcne_pkg::*;

  localparam int unsigned TOP_IDX  = 32'h7FFF_FFFF;
  localparam int unsigned QUIET_MAX = 20000;
  localparam int unsigned HOLD_LEN  = 400;
  localparam logic [2:0]  CMD_RSVD_A = 3'd6;
  localparam logic [2:0]  CMD_RSVD_B = 3'd7;
  localparam logic [2:0]  REG_RSVD   = 3'd6;

  typedef struct {
    logic [2:0]  cmd;
    logic [30:0] mt, ri, rt, lc;
    logic [63:0] cw;
    logic [3:0]  sid;
    logic        vg, le;
  } msg_t;

  typedef struct {
    logic [2:0]  kind;
    logic [30:0] term;
    logic [2:0]  status;
    logic        ok;
    logic [30:0] index, last_term;
    logic [63:0] command;
    logic        timer, more;
    logic [1:0]  role;
  } reply_t;

  typedef struct {
    bit          is_cfg;
    logic [2:0]  reg_idx;
    logic [30:0] reg_val;
    msg_t        m;
    bit          pin;
    logic [2:0]  pk, ps;
    logic [30:0] pidx;
  } row_t;

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [30:0] cfg_data;
  logic in_valid, in_ready;
  logic [2:0] in_cmd;
  logic [30:0] in_msg_term, in_ref_index, in_ref_term, in_leader_commit;
  logic [63:0] in_entry_command;
  logic [3:0] in_sender_id;
  logic in_vote_granted, in_last_entry;
  logic out_valid, out_ready;
  logic [2:0] out_kind, out_status;
  logic [30:0] out_term, out_index, out_last_term;
  logic [63:0] out_command;
  logic out_success, out_timer_reset, out_more_pending;
  logic [1:0] out_role;

  raft_consensus_node_engine_top u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd), .in_msg_term(in_msg_term),
    .in_ref_index(in_ref_index), .in_ref_term(in_ref_term),
    .in_leader_commit(in_leader_commit), .in_entry_command(in_entry_command),
    .in_sender_id(in_sender_id), .in_vote_granted(in_vote_granted),
    .in_last_entry(in_last_entry),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind), .out_term(out_term),
    .out_status(out_status), .out_success(out_success), .out_index(out_index),
    .out_last_term(out_last_term), .out_command(out_command),
    .out_timer_reset(out_timer_reset), .out_more_pending(out_more_pending),
    .out_role(out_role)
  );

  // Predicted node state.
  int unsigned n_id, n_count, snap_idx, snap_term, cur_term, voted, commit, applied;
  int unsigned log_end, tally, pend;
  role_t n_role;
  bit open;
  int unsigned log_term [LOG_DEPTH];
  logic [63:0] log_cmd [LOG_DEPTH];

  reply_t reply_q[$];
  row_t plan_q[$];
  int errors, n_items, n_results, n_cfg;
  bit pin_on;
  logic [2:0] pin_kind, pin_status;
  logic [30:0] pin_index;
  bit idle_on, stall_on, hold_req;
  int unsigned quiet;

  function automatic int unsigned sat_next(int unsigned v);
    return v < TOP_IDX ? v + 1 : TOP_IDX;
  endfunction

  function automatic int unsigned slot_at(int unsigned idx);
    return (idx - snap_idx - 1) % LOG_DEPTH;
  endfunction

  function automatic int unsigned term_of(int unsigned idx);
    if (idx <= snap_idx) return snap_term;
    return log_term[slot_at(idx)];
  endfunction

  function automatic void adopt_term(int unsigned t);
    cur_term = t;
    voted = NO_VOTE;
    n_role = ROLE_FOLLOWER;
    tally = 0;
    open = 0;
  endfunction

  function automatic reply_t make_reply(kind_t k, status_t st, bit ok, int unsigned index,
                                        int unsigned last, logic [63:0] word, bit timer);
    reply_t r;
    r.kind = k;
    r.term = cur_term;
    r.status = st;
    r.ok = ok;
    r.index = index;
    r.last_term = last;
    r.command = word;
    r.timer = timer;
    r.more = applied < commit;
    r.role = n_role;
    return r;
  endfunction

  function automatic reply_t close_append();
    open = 0;
    if (pend > commit) commit = pend < log_end ? pend : log_end;
    return make_reply(KIND_APP_RSP, ST_OK, 1, log_end, 0, 0, 1);
  endfunction

  function automatic void empty_log();
    log_end = snap_idx;
    applied = snap_idx;
    commit = 0;
    pend = 0;
    open = 0;
  endfunction

  // Register write as seen by the node.
  function automatic void node_config(logic [2:0] idx, logic [30:0] val);
    int unsigned v;
    case (idx)
      REG_NODE_ID:    n_id = val[3:0];
      REG_NODE_COUNT: n_count = val[4:0];
      REG_SNAP_INDEX: begin
        snap_idx = val;
        empty_log();
      end
      REG_SNAP_TERM:  snap_term = val;
      REG_REST_TERM:  cur_term = val;
      REG_REST_VOTE: begin
        v = val[4:0];
        voted = v > NO_VOTE ? NO_VOTE : v;
      end
      default: ;
    endcase
  endfunction

  // One message through the node; returns 1 when it yields a reply.
  function automatic bit raft_step(input msg_t m, output reply_t r);
    int unsigned mt, ri, rt, hint, base, idx, majority, s;
    mt = m.mt;
    ri = m.ri;
    rt = m.rt;
    majority = n_count / 2 + 1;
    r = '{default: 0};
    case (m.cmd)
      CMD_APP_HDR: begin
        if (mt < cur_term) begin
          open = 0;
          r = make_reply(KIND_APP_RSP, ST_STALE, 0, 0, 0, 0, 0);
          return 1;
        end
        if (mt > cur_term) adopt_term(mt);
        n_role = ROLE_FOLLOWER;
        tally = 0;
        open = 0;
        if (ri > log_end) begin
          r = make_reply(KIND_APP_RSP, ST_TOO_NEW, 0, sat_next(log_end), 0, 0, 1);
          return 1;
        end
        if (ri < snap_idx) begin
          r = make_reply(KIND_APP_RSP, ST_TOO_OLD, 0, sat_next(snap_idx), 0, 0, 1);
          return 1;
        end
        if (term_of(ri) != rt) begin
          // Walk down for the first entry whose term differs from the prev entry.
          hint = ri;
          base = term_of(ri);
          for (idx = ri; idx > snap_idx; idx--) begin
            if (term_of(idx) != base) begin
              hint = idx + 1;
              break;
            end
          end
          r = make_reply(KIND_APP_RSP, ST_MISMATCH, 0, hint, 0, 0, 1);
          return 1;
        end
        pend = m.lc;
        if (m.le) begin
          r = close_append();
          return 1;
        end
        open = 1;
        return 0;
      end
      CMD_APP_ENT: begin
        if (!open) return 0;
        if (ri <= snap_idx || ri <= commit) begin
          // Already covered by the snapshot or the commit point.
        end else if (ri <= log_end) begin
          s = slot_at(ri);
          if (log_term[s] != rt) begin
            log_term[s] = rt;
            log_cmd[s] = m.cw;
            log_end = ri;
          end
        end else if (ri == log_end + 1) begin
          if (log_end - snap_idx >= LOG_DEPTH) begin
            open = 0;
            r = make_reply(KIND_APP_RSP, ST_FULL, 0, log_end, 0, 0, 1);
            return 1;
          end
          s = slot_at(ri);
          log_term[s] = rt;
          log_cmd[s] = m.cw;
          log_end = ri;
        end else begin
          open = 0;
          r = make_reply(KIND_APP_RSP, ST_TOO_NEW, 0, sat_next(log_end), 0, 0, 1);
          return 1;
        end
        if (m.le) begin
          r = close_append();
          return 1;
        end
        return 0;
      end
      CMD_VOTE_REQ: begin
        if (mt < cur_term) begin
          r = make_reply(KIND_VOTE_RSP, ST_STALE, 0, 0, 0, 0, 0);
          return 1;
        end
        if (mt > cur_term) adopt_term(mt);
        base = term_of(log_end);
        if (!(rt > base || (rt == base && ri >= log_end))) begin
          r = make_reply(KIND_VOTE_RSP, ST_BEHIND, 0, 0, 0, 0, 0);
          return 1;
        end
        if (voted != NO_VOTE && voted != m.sid) begin
          r = make_reply(KIND_VOTE_RSP, ST_VOTED, 0, 0, 0, 0, 0);
          return 1;
        end
        voted = m.sid;
        r = make_reply(KIND_VOTE_RSP, ST_OK, 1, 0, 0, 0, 1);
        return 1;
      end
      CMD_VOTE_RSP: begin
        if (mt > cur_term) begin
          adopt_term(mt);
          return 0;
        end
        if (mt < cur_term || n_role != ROLE_CANDIDATE || !m.vg) return 0;
        if (tally < 31) tally++;
        if (tally >= majority) begin
          n_role = ROLE_LEADER;
          tally = 0;
          r = make_reply(KIND_LEADER, ST_OK, 1, log_end, 0, 0, 0);
          return 1;
        end
        return 0;
      end
      CMD_TIMEOUT: begin
        if (n_role == ROLE_LEADER) return 0;
        n_role = ROLE_CANDIDATE;
        cur_term = sat_next(cur_term);
        voted = n_id;
        tally = 1;
        open = 0;
        if (tally >= majority) begin
          n_role = ROLE_LEADER;
          tally = 0;
          r = make_reply(KIND_LEADER, ST_OK, 1, log_end, 0, 0, 1);
          return 1;
        end
        r = make_reply(KIND_VOTE_REQ, ST_OK, 0, log_end, term_of(log_end), 0, 1);
        return 1;
      end
      CMD_APPLY: begin
        if (applied >= commit) return 0;
        applied++;
        r = make_reply(KIND_APPLY, ST_OK, 0, applied, 0,
                       applied > snap_idx ? log_cmd[slot_at(applied)] : 64'd0, 0);
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    if (errors <= 60) $display("MISMATCH %s: got %0h expected %0h", what, got, want);
  endtask

  // Clock generation.
  initial clk = 0;
  always #5 clk = ~clk;

  // Monitor: check results, then predict for accepted items and register writes.
  always @(posedge clk) begin
    reply_t e, r;
    bit has;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        n_results++;
        if (reply_q.size() == 0) begin
          report("result with nothing expected, kind", out_kind, 0);
        end else begin
          e = reply_q.pop_front();
          if (out_kind !== e.kind) report("kind", out_kind, e.kind);
          if (out_term !== e.term) report("term", out_term, e.term);
          if (out_status !== e.status) report("status", out_status, e.status);
          if (out_success !== e.ok) report("success", out_success, e.ok);
          if (out_index !== e.index) report("index", out_index, e.index);
          if (out_last_term !== e.last_term) report("last term", out_last_term, e.last_term);
          if (out_command !== e.command) report("command", out_command, e.command);
          if (out_timer_reset !== e.timer) report("timer reset", out_timer_reset, e.timer);
          if (out_more_pending !== e.more) report("more pending", out_more_pending, e.more);
          if (out_role !== e.role) report("role", out_role, e.role);
        end
      end
      if (in_valid && in_ready) begin
        has = raft_step('{in_cmd, in_msg_term, in_ref_index, in_ref_term, in_leader_commit,
                          in_entry_command, in_sender_id, in_vote_granted, in_last_entry}, r);
        // Directed rows carry a hand-written kind, status and index.
        if (pin_on && !has) report("pinned row gave no result, kind", 0, pin_kind);
        if (pin_on) begin
          r.kind = pin_kind;
          r.status = pin_status;
          r.index = pin_index;
        end
        if (has) reply_q.push_back(r);
      end
      if (cfg_valid && cfg_ready) node_config(cfg_index, cfg_data);
    end
  end

  // Watchdog on cycles with no transfer anywhere.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= QUIET_MAX) begin
      $display("Watchdog expired with %0d results outstanding", reply_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_req) begin
      out_ready = 0;
      repeat (HOLD_LEN) @(negedge clk);
      hold_req = 0;
    end else begin
      out_ready = !stall_on || ($urandom_range(99) >= 37);
    end
  end

  // Offer one item, starting at a falling edge; returns at the falling edge after transfer.
  task automatic send_item(msg_t m, bit pin = 0, logic [2:0] pk = 0, logic [2:0] ps = 0,
                           logic [30:0] pidx = 0);
    if (idle_on && $urandom_range(99) < 37) begin
      in_valid = 0;
      do @(negedge clk); while ($urandom_range(99) < 37);
    end
    in_cmd = m.cmd;
    in_msg_term = m.mt;
    in_ref_index = m.ri;
    in_ref_term = m.rt;
    in_leader_commit = m.lc;
    in_entry_command = m.cw;
    in_sender_id = m.sid;
    in_vote_granted = m.vg;
    in_last_entry = m.le;
    pin_on = pin;
    pin_kind = pk;
    pin_status = ps;
    pin_index = pidx;
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
    n_items++;
    @(negedge clk);
  endtask

  // Wait for the node to drain, then write one register.
  task automatic cfg_write(logic [2:0] idx, logic [30:0] val);
    in_valid = 0;
    while (reply_q.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1;
    do @(posedge clk); while (!cfg_ready);
    n_cfg++;
    @(negedge clk);
    cfg_valid = 0;
  endtask

  function automatic msg_t mk(logic [2:0] cmd, int unsigned mt, int unsigned ri = 0,
                              int unsigned rt = 0, int unsigned lc = 0, logic [63:0] cw = 0,
                              logic [3:0] sid = 0, bit vg = 0, bit le = 0);
    msg_t m;
    m = '{cmd, mt, ri, rt, lc, cw, sid, vg, le};
    return m;
  endfunction

  function automatic void add_msg(msg_t m);
    row_t r;
    r = '{default: 0};
    r.m = m;
    plan_q.push_back(r);
  endfunction

  function automatic void add_pinned(msg_t m, kind_t k, status_t st, int unsigned idx);
    row_t r;
    r = '{default: 0};
    r.m = m;
    r.pin = 1;
    r.pk = k;
    r.ps = st;
    r.pidx = idx;
    plan_q.push_back(r);
  endfunction

  function automatic void add_cfg(logic [2:0] idx, int unsigned val);
    row_t r;
    r = '{default: 0};
    r.is_cfg = 1;
    r.reg_idx = idx;
    r.reg_val = val;
    plan_q.push_back(r);
  endfunction

  // Random traffic, mostly well-formed append streams and elections.
  task automatic random_phase(int n, int hold_at, int drain_at);
    int sent, sel, k, nent;
    int unsigned prev, back, len, mt, ri, rt;
    msg_t m;
    sent = 0;
    while (sent < n) begin
      if (sent >= hold_at && hold_at >= 0 && !hold_req) begin
        hold_req = 1;
        hold_at = -1;
      end
      if (sent >= drain_at && drain_at >= 0) begin
        in_valid = 0;
        while (reply_q.size() != 0) @(negedge clk);
        drain_at = -1;
      end
      sel = $urandom_range(99);
      if (sel < 40) begin
        len = log_end - snap_idx;
        back = $urandom_range(0, len < 6 ? len : 6);
        prev = log_end - back;
        mt = $urandom_range(9) == 0 ? sat_next(cur_term) : cur_term;
        rt = $urandom_range(7) == 0 ? $urandom_range(0, 15) : term_of(prev);
        nent = $urandom_range(0, 5);
        if (nent > TOP_IDX - prev) nent = TOP_IDX - prev;
        m = mk(CMD_APP_HDR, mt, prev, rt, log_end + $urandom_range(0, 4) > TOP_IDX ?
               TOP_IDX : log_end + $urandom_range(0, 4), 0, 0, 0, nent == 0);
        send_item(m);
        sent++;
        for (k = 1; k <= nent; k++) begin
          ri = prev + k;
          if ($urandom_range(19) == 0 && ri < TOP_IDX - 3) ri += 3;
          rt = ($urandom_range(4) == 0 && mt > 0) ? mt - 1 : mt;
          send_item(mk(CMD_APP_ENT, mt, ri, rt, 0, {$urandom, $urandom}, 0, 0, k == nent));
          sent++;
        end
      end else if (sel < 52) begin
        mt = $urandom_range(5) == 0 && cur_term > 0 ? cur_term - 1 :
             cur_term + $urandom_range(0, 1) > TOP_IDX ? TOP_IDX : cur_term + $urandom_range(0, 1);
        rt = term_of(log_end);
        rt = $urandom_range(0, 2) == 0 && rt > 0 ? rt - 1 :
             $urandom_range(0, 3) == 0 && rt < TOP_IDX ? rt + 1 : rt;
        ri = $urandom_range(0, 1) && log_end > 0 ? log_end - 1 :
             log_end < TOP_IDX ? log_end + $urandom_range(0, 1) : log_end;
        send_item(mk(CMD_VOTE_REQ, mt, ri, rt, 0, 0, $urandom_range(15)));
        sent++;
      end else if (sel < 62) begin
        mt = $urandom_range(7) == 0 ? sat_next(cur_term) : cur_term;
        send_item(mk(CMD_VOTE_RSP, mt, 0, 0, 0, 0, 0, $urandom_range(3) != 0));
        sent++;
      end else if (sel < 70) begin
        send_item(mk(CMD_TIMEOUT, $urandom & TOP_IDX));
        sent++;
      end else if (sel < 85) begin
        send_item(mk(CMD_APPLY, 0));
        sent++;
      end else begin
        // Noise: every field at random, but the message term is the current term half the time.
        m = mk($urandom_range(7), $urandom_range(1) ? ($urandom & TOP_IDX) : cur_term,
               $urandom & TOP_IDX, $urandom & TOP_IDX, $urandom & TOP_IDX,
               {$urandom, $urandom}, $urandom_range(15), $urandom_range(1),
               $urandom_range(1));
        send_item(m);
        sent++;
      end
    end
  endtask

  initial begin
    int unsigned i;
    int p;
    int unsigned ph_id [4] = '{0, 15, 7, 3};
    int unsigned ph_cnt [4] = '{3, 16, 1, 5};
    int unsigned ph_snap [4] = '{0, 1000, TOP_IDX - 60, 37};
    int unsigned ph_sterm [4] = '{0, 3, TOP_IDX, 9};
    int unsigned ph_rterm [4] = '{1, 3, 2000, 9};
    int unsigned ph_rvote [4] = '{16, 5, 31, 2};

    rst_n = 0;
    cfg_valid = 0;
    cfg_index = 0;
    cfg_data = 0;
    in_valid = 0;
    in_cmd = 0;
    in_msg_term = 0;
    in_ref_index = 0;
    in_ref_term = 0;
    in_leader_commit = 0;
    in_entry_command = 0;
    in_sender_id = 0;
    in_vote_granted = 0;
    in_last_entry = 0;
    out_ready = 0;
    idle_on = 1;
    stall_on = 1;
    hold_req = 0;
    pin_on = 0;
    pin_kind = 0;
    pin_status = 0;
    pin_index = 0;
    errors = 0;
    quiet = 0;
    n_items = 0;
    n_results = 0;
    n_cfg = 0;

    // Node state after reset.
    n_id = 0;
    n_count = 3;
    snap_idx = 0;
    snap_term = 0;
    cur_term = 0;
    voted = NO_VOTE;
    n_role = ROLE_FOLLOWER;
    tally = 0;
    empty_log();

    // Directed table: extremes, every command and the named corner cases.
    add_msg(mk(CMD_APPLY, 0));
    add_msg(mk(CMD_APP_ENT, 0, 1, 1));
    add_pinned(mk(CMD_APP_HDR, 0, 5), KIND_APP_RSP, ST_TOO_NEW, 1);
    add_pinned(mk(CMD_VOTE_REQ, 0, 0, 0, 0, 0, 3), KIND_VOTE_RSP, ST_OK, 0);
    add_pinned(mk(CMD_VOTE_REQ, 0, 0, 0, 0, 0, 4), KIND_VOTE_RSP, ST_VOTED, 0);
    add_msg(mk(CMD_TIMEOUT, 0));
    add_pinned(mk(CMD_VOTE_RSP, 1, 0, 0, 0, 0, 0, 1), KIND_LEADER, ST_OK, 0);
    add_msg(mk(CMD_TIMEOUT, 0));
    add_pinned(mk(CMD_APP_HDR, 0), KIND_APP_RSP, ST_STALE, 0);
    add_msg(mk(CMD_APP_HDR, 2, 0, 0, 2));
    add_msg(mk(CMD_APP_ENT, 2, 1, 2, 0, '1));
    add_msg(mk(CMD_APP_ENT, 2, 2, 2, 0, 64'd0));
    add_pinned(mk(CMD_APP_ENT, 2, 3, 2, 0, 64'h0123_4567_89ab_cdef, 0, 0, 1),
               KIND_APP_RSP, ST_OK, 3);
    add_pinned(mk(CMD_APPLY, 0), KIND_APPLY, ST_OK, 1);
    add_pinned(mk(CMD_APPLY, 0), KIND_APPLY, ST_OK, 2);
    add_msg(mk(CMD_APPLY, 0));
    add_msg(mk(CMD_APP_HDR, 2, 3, 1));
    add_pinned(mk(CMD_VOTE_REQ, 3, 9, 0, 0, 0, 1), KIND_VOTE_RSP, ST_BEHIND, 0);
    add_msg(mk(CMD_VOTE_RSP, 5));
    add_msg(mk(CMD_APP_HDR, 5, 3, 2));
    add_pinned(mk(CMD_APP_ENT, 5, 7, 5), KIND_APP_RSP, ST_TOO_NEW, 4);
    add_msg(mk(CMD_RSVD_A, TOP_IDX, TOP_IDX, TOP_IDX, TOP_IDX, '1, 15, 1, 1));
    add_msg(mk(CMD_RSVD_B, 0));
    add_pinned(mk(CMD_APP_HDR, TOP_IDX, 0, 0, TOP_IDX, 0, 0, 0, 1), KIND_APP_RSP, ST_OK, 3);
    add_msg(mk(CMD_TIMEOUT, 0));
    add_cfg(REG_SNAP_INDEX, TOP_IDX);
    add_cfg(REG_SNAP_TERM, TOP_IDX);
    add_pinned(mk(CMD_APP_HDR, TOP_IDX), KIND_APP_RSP, ST_TOO_OLD, TOP_IDX);
    add_cfg(REG_NODE_COUNT, 1);
    add_cfg(REG_NODE_ID, 15);
    add_pinned(mk(CMD_TIMEOUT, 0), KIND_LEADER, ST_OK, TOP_IDX);
    add_cfg(REG_REST_VOTE, 31);
    add_cfg(REG_RSVD, 5);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    foreach (plan_q[j]) begin
      if (plan_q[j].is_cfg)
        cfg_write(plan_q[j].reg_idx, plan_q[j].reg_val);
      else
        send_item(plan_q[j].m, plan_q[j].pin, plan_q[j].pk, plan_q[j].ps, plan_q[j].pidx);
    end

    // Fill the log to capacity, then one entry more.
    cfg_write(REG_NODE_COUNT, 3);
    cfg_write(REG_SNAP_INDEX, 0);
    cfg_write(REG_SNAP_TERM, 0);
    cfg_write(REG_REST_TERM, 10);
    send_item(mk(CMD_APP_HDR, 10, 0, 0, 500));
    for (i = 1; i <= LOG_DEPTH + 1; i++)
      send_item(mk(CMD_APP_ENT, 10, i, 10, 0, {$urandom, $urandom}, 0, 0, i == LOG_DEPTH + 1));
    send_item(mk(CMD_APPLY, 0));

    // Random phases, each under its own register setting.
    for (p = 0; p < 4; p++) begin
      cfg_write(REG_NODE_ID, ph_id[p]);
      cfg_write(REG_NODE_COUNT, ph_cnt[p]);
      cfg_write(REG_SNAP_INDEX, ph_snap[p]);
      cfg_write(REG_SNAP_TERM, ph_sterm[p]);
      cfg_write(REG_REST_TERM, ph_rterm[p]);
      cfg_write(REG_REST_VOTE, ph_rvote[p]);
      if (p == 3) cfg_write(CMD_RSVD_B, 1);
      idle_on = (p != 2);
      stall_on = (p != 2);
      random_phase(210, p == 1 ? 40 : -1, p == 0 ? 100 : -1);
    end

    // Drain and let the last items settle.
    in_valid = 0;
    while (reply_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("Covered %0d items, %0d results and %0d register writes", n_items, n_results,
             n_cfg);
    $display("including a filled log, elections, hint walks and a long receiver hold-off.");
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### files.f
+incdir+src
src/rcne_pkg.sv
src/rcne_ram.sv
src/rcne_ctrl.sv
src/rcne_dpath.sv
src/raft_consensus_node_engine_top.sv
tb/sv/tb.sv
